[rtl/hiqp_pkg.sv]
// Package for the quadratic-probe hash insert block: beat types, result codes,
// hash and modulo constants, and the control structs between its modules.
// No dependencies.
package hiqp_pkg;

    localparam int KEY_W    = 64;
    localparam int LEN_W    = 4;
    localparam int SIZE_W   = 11;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    // slots in the table RAMs; positions and table_size are sized for this
    localparam int TABLE_DEPTH = 1024;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;

    localparam logic [STATUS_W-1:0] STATUS_NEW   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // hash: last three characters, offset from 'A', base 32
    localparam int         HASH_CHARS  = 3;
    localparam int         RADIX_SHIFT = 5;
    localparam logic [7:0] CHAR_A      = 8'h41;

    // |sum| < 2^18; the remainder unit retires 3 dividend bits a cycle
    localparam int MAG_W     = 18;
    localparam int SUM_W     = MAG_W + 1;
    localparam int MOD_BITS  = 3;
    localparam int MOD_ITERS = MAG_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_ITERS);

    typedef struct packed {
        logic [KEY_W-1:0] key_chars;
        logic [LEN_W-1:0] key_length;
    } key_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
    } res_beat_t;

    typedef struct packed {
        logic             start;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] residue;
    } mod_rsp_t;

    typedef struct packed {
        logic load;
        logic advance;
    } probe_ctrl_t;

endpackage

[rtl/hash_insert_quadratic_probe_top.sv]
// Hash insert with alternating quadratic probing, top level.
// Uses hiqp_pkg, hiqp_ram, hiqp_mod, hiqp_probe.
//
// One key is handled at a time. After an accepted beat the hash remainder is worked
// out in the iterative remainder unit, then the table is probed one slot per cycle
// out of the synchronous used/key RAMs, up to the effective table size minus one
// probes past the home slot. The state goes back to idle for the next key when the
// result is loaded into the output register. After reset a clearing pass writes
// all TABLE_DEPTH (1024) used marks to empty; keys are not taken until it ends,
// while table_size writes are accepted at any time. The result sits in an output
// register, so the next key is accepted while it waits.
module hash_insert_quadratic_probe_top #(
    parameter int KEY_CHARS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hiqp_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                        key_valid,
    output logic                        key_ready,
    input  hiqp_pkg::key_beat_t         key_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output hiqp_pkg::res_beat_t         res_data
);
    import hiqp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = KEY_CHARS * 8;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] m_reg, m_eff;
    logic [AW-1:0]     clr_addr_reg;
    logic [KW-1:0]     key_reg, key_masked;
    logic [SIZE_W-1:0] home_reg;
    logic [SIZE_W-1:0] chk_slot_reg, chk_slot_next;
    logic [SIZE_W-1:0] chk_idx_reg, chk_idx_next;
    res_beat_t         pend_reg, pend_next;
    logic              res_valid_reg;
    res_beat_t         res_data_reg;

    logic [LEN_W-1:0]  len_clamped;
    logic [2:0]        byte_idx;
    logic [7:0]        ch;
    logic [SUM_W-1:0]  term, hash_sum, hash_abs;

    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;
    probe_ctrl_t       probe_ctrl;
    logic [SIZE_W-1:0] probe_slot;

    logic              used_we, used_wdata, used_q;
    logic [AW-1:0]     used_waddr, raddr;
    logic              key_we;
    logic [KW-1:0]     key_q;
    logic              slot_empty, slot_same, probe_last;

    // ---------------------------------------------------------------- input side
    always_comb
    begin
        if (size_reg == '0)
        begin
            m_eff = SIZE_W'(1);
        end
        else if (int'(size_reg) > TABLE_DEPTH)
        begin
            m_eff = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            m_eff = size_reg;
        end
    end

    assign len_clamped = (key_data.key_length > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS)
                                                                    : key_data.key_length;

    always_comb
    begin
        for (int b = 0; b < KEY_CHARS; b++)
        begin
            key_masked[b*8 +: 8] = (LEN_W'(b) < len_clamped) ? key_data.key_chars[b*8 +: 8]
                                                              : 8'h00;
        end
    end

    // last char is the low digit; two's complement wraps cleanly in SUM_W bits
    always_comb
    begin
        hash_sum = '0;
        byte_idx = '0;
        ch       = '0;
        term     = '0;
        for (int i = 0; i < HASH_CHARS; i++)
        begin
            if (len_clamped > LEN_W'(i))
            begin
                byte_idx = 3'(len_clamped - LEN_W'(i + 1));
                ch       = key_data.key_chars[8*byte_idx +: 8];
                term     = SUM_W'(ch) - SUM_W'(CHAR_A);
                hash_sum = hash_sum + (term << (RADIX_SHIFT * i));
            end
        end
        hash_abs = hash_sum[SUM_W-1] ? SUM_W'(-hash_sum) : hash_sum;
    end

    assign key_ready = (state_reg == ST_IDLE);

    assign mod_req.start     = key_valid && key_ready;
    assign mod_req.negative  = hash_sum[SUM_W-1];
    assign mod_req.magnitude = hash_abs[MAG_W-1:0];

    hiqp_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mod_req),
        .modulus (m_reg),
        .rsp     (mod_rsp)
    );

    // probe offsets are taken from the home slot, not from the last probe
    hiqp_probe u_probe (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (probe_ctrl),
        .home    (home_reg),
        .modulus (m_reg),
        .slot    (probe_slot)
    );

    // ---------------------------------------------------------------- table RAMs
    hiqp_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (raddr),
        .rdata (used_q)
    );

    hiqp_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (AW'(chk_slot_reg)),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (key_q)
    );

    // RAM output always belongs to chk_slot_reg while probing
    assign slot_empty = !used_q;
    assign slot_same  = used_q && (key_q == key_reg);
    assign probe_last = (chk_idx_reg == m_reg - SIZE_W'(1));

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next         = state_reg;
        chk_slot_next      = chk_slot_reg;
        chk_idx_next       = chk_idx_reg;
        pend_next          = pend_reg;
        probe_ctrl.load    = 1'b0;
        probe_ctrl.advance = 1'b0;
        used_we            = 1'b0;
        used_waddr         = AW'(chk_slot_reg);
        used_wdata         = 1'b1;
        key_we             = 1'b0;
        raddr              = AW'(probe_slot);

        unique case (state_reg)
            ST_CLEAR:
            begin
                used_we    = 1'b1;
                used_waddr = clr_addr_reg;
                used_wdata = 1'b0;
                if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (key_valid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                raddr = AW'(mod_rsp.residue);
                if (mod_rsp.done)
                begin
                    chk_slot_next   = mod_rsp.residue;
                    chk_idx_next    = '0;
                    probe_ctrl.load = 1'b1;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                priority if (slot_empty)
                begin
                    used_we            = 1'b1;
                    key_we             = 1'b1;
                    pend_next.status   = STATUS_NEW;
                    pend_next.position = chk_slot_reg[POS_W-1:0];
                    state_next         = ST_DONE;
                end
                else if (slot_same)
                begin
                    pend_next.status   = STATUS_FOUND;
                    pend_next.position = chk_slot_reg[POS_W-1:0];
                    state_next         = ST_DONE;
                end
                else if (probe_last)
                begin
                    pend_next.status   = STATUS_FULL;
                    pend_next.position = '0;
                    state_next         = ST_DONE;
                end
                else
                begin
                    probe_ctrl.advance = 1'b1;
                    chk_slot_next      = probe_slot;
                    chk_idx_next       = chk_idx_reg + SIZE_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            size_reg      <= SIZE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && (!res_valid_reg || res_ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_req.start)
        begin
            key_reg <= key_masked;
            m_reg   <= m_eff;
        end
        if (probe_ctrl.load)
        begin
            home_reg <= mod_rsp.residue;
        end
        chk_slot_reg <= chk_slot_next;
        chk_idx_reg  <= chk_idx_next;
        pend_reg     <= pend_next;
        if (state_reg == ST_DONE && (!res_valid_reg || res_ready))
        begin
            res_data_reg <= pend_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ---------------------------------------------------------------- checks
    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready |=> state_reg == ST_HASH)
        else $error("accepted key did not start hashing");

    a_home_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HASH && mod_rsp.done |-> mod_rsp.residue < m_reg)
        else $error("home slot outside table");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> chk_slot_reg < m_reg && chk_idx_reg < m_reg)
        else $error("probe slot or count outside table");

    a_insert_only_when_probing: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> state_reg == ST_PROBE && used_we && used_wdata)
        else $error("key write outside an insert");

endmodule

[rtl/hiqp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hiqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/hiqp_mod.sv]
// Iterative remainder unit: signed hash sum modulo the table size,
// restoring division, MOD_BITS quotient bits per cycle. Uses hiqp_pkg.
module hiqp_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hiqp_pkg::mod_req_t        req,
    input  logic [hiqp_pkg::SIZE_W-1:0] modulus,
    output hiqp_pkg::mod_rsp_t        rsp
);
    import hiqp_pkg::*;

    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic                 neg_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SIZE_W:0]      trial;

    // remainder stays below the modulus, so one compare-subtract per bit
    always_comb
    begin
        rem_next = rem_reg;
        mag_next = mag_reg;
        trial    = '0;
        for (int j = 0; j < MOD_BITS; j++)
        begin
            trial    = {rem_next, mag_next[MAG_W-1]};
            mag_next = mag_next << 1;
            if (trial >= {1'b0, modulus})
            begin
                trial = trial - {1'b0, modulus};
            end
            rem_next = trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mag_reg <= req.magnitude;
            rem_reg <= '0;
            neg_reg <= req.negative;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_ITERS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // negative sum: fold the remainder back into [0, m)
    assign rsp.done    = done_reg;
    assign rsp.residue = (neg_reg && rem_reg != '0) ? modulus - rem_reg : rem_reg;

endmodule

[rtl/hiqp_probe.sv]
// Probe slot generator: home +1, -1, +4, -4, ... modulo the table size,
// squares kept incrementally with compare-subtract. Uses hiqp_pkg.
module hiqp_probe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hiqp_pkg::probe_ctrl_t       ctrl,
    input  logic [hiqp_pkg::SIZE_W-1:0] home,
    input  logic [hiqp_pkg::SIZE_W-1:0] modulus,
    output logic [hiqp_pkg::SIZE_W-1:0] slot
);
    import hiqp_pkg::*;

    logic [SIZE_W-1:0] sq_reg, sq_next;
    logic [SIZE_W-1:0] step_reg, step_next;   // (2k+1) mod m
    logic              minus_reg;
    logic [SIZE_W:0]   plus_sum, sq_sum, step_sum;
    logic [SIZE_W-1:0] step_init;

    always_comb
    begin
        plus_sum = {1'b0, home} + {1'b0, sq_reg};
        if (minus_reg)
        begin
            if (home >= sq_reg)
            begin
                slot = home - sq_reg;
            end
            else
            begin
                slot = SIZE_W'({1'b0, home} + {1'b0, modulus} - {1'b0, sq_reg});
            end
        end
        else if (plus_sum >= {1'b0, modulus})
        begin
            slot = SIZE_W'(plus_sum - {1'b0, modulus});
        end
        else
        begin
            slot = plus_sum[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        sq_sum   = {1'b0, sq_reg} + {1'b0, step_reg};
        step_sum = {1'b0, step_reg} + (SIZE_W+1)'(2);
        sq_next   = (sq_sum >= {1'b0, modulus}) ? SIZE_W'(sq_sum - {1'b0, modulus})
                                                : sq_sum[SIZE_W-1:0];
        step_next = (step_sum >= {1'b0, modulus}) ? SIZE_W'(step_sum - {1'b0, modulus})
                                                  : step_sum[SIZE_W-1:0];
        // 3 mod m for the sizes that can probe at all
        if (modulus == SIZE_W'(2))
        begin
            step_init = SIZE_W'(1);
        end
        else if (modulus == SIZE_W'(3))
        begin
            step_init = '0;
        end
        else
        begin
            step_init = SIZE_W'(3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sq_reg   <= SIZE_W'(1);
            step_reg <= step_init;
        end
        else if (ctrl.advance && minus_reg)
        begin
            sq_reg   <= sq_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minus_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            minus_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            minus_reg <= !minus_reg;
        end
    end

endmodule

[test/tb_hash_insert_quadratic_probe_top.sv]
// Testbench for hash_insert_quadratic_probe_top: directed and random key inserts checked
// beat by beat against a shadow hash table, over several table sizes and idle patterns.
// Depends on hiqp_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module tb_hash_insert_quadratic_probe_top;
    import hiqp_pkg::*;

    localparam int MAX_CYCLES = 2_000_000;
    localparam int SETTLE_CYCLES = 40;

    // Shadow copy of the hash table plus the queue of results still owed by the block.
    class hash_table_scoreboard;
        localparam int DEPTH = 1024;
        localparam int MAX_LEN = 8;

        bit          slot_used [DEPTH];
        logic [63:0] slot_key [DEPTH];
        logic [SIZE_W-1:0] size_cfg;
        res_beat_t   pending_results[$];
        int          mismatches;
        int          n_new;
        int          n_found;
        int          n_full;

        function new();
            size_cfg = SIZE_RESET;
            mismatches = 0;
            n_new = 0;
            n_found = 0;
            n_full = 0;
        endfunction

        function logic [STATUS_W-1:0] claim_slot(int unsigned s, logic [63:0] key);
            if (!slot_used[s])
            begin
                slot_used[s] = 1'b1;
                slot_key[s] = key;
                return STATUS_NEW;
            end
            if (slot_key[s] == key)
                return STATUS_FOUND;
            return STATUS_FULL;   // taken by a different key
        endfunction

        function res_beat_t predict_insert(key_beat_t beat);
            int unsigned m;
            int unsigned len;
            int unsigned home;
            int unsigned s;
            int unsigned count;
            int unsigned i;
            int          k;
            longint      sum;
            longint      weight;
            longint      sq;
            logic [63:0] key;
            logic [STATUS_W-1:0] code;
            bit          minus;
            res_beat_t   r;

            m = (size_cfg == 0) ? 1 : ((size_cfg > DEPTH) ? DEPTH : size_cfg);
            len = (beat.key_length > MAX_LEN) ? MAX_LEN : beat.key_length;
            key = (len >= MAX_LEN) ? beat.key_chars
                                   : beat.key_chars & ((64'd1 << (len * 8)) - 64'd1);

            // last char is the low base-32 digit; offsets from 'A' may go negative
            sum = 0;
            weight = 1;
            for (k = 1; k <= HASH_CHARS && k <= int'(len); k++)
            begin
                sum += (longint'(key[(int'(len) - k) * 8 +: 8]) - longint'(CHAR_A)) * weight;
                weight *= 32;
            end
            sum = sum % longint'(m);
            if (sum < 0)
                sum += longint'(m);
            home = int'(sum);

            r.status = STATUS_FULL;
            r.position = '0;
            code = claim_slot(home, key);
            if (code != STATUS_FULL)
            begin
                r.status = code;
                r.position = home[POS_W-1:0];
                return r;
            end
            count = 1;
            minus = 1'b0;
            for (i = 1; i < m; i++)
            begin
                sq = (longint'(count) * count) % m;
                if (!minus)
                    s = int'((longint'(home) + sq) % m);
                else
                    s = int'((longint'(home) + m - sq) % m);
                if (minus)
                    count++;
                minus = !minus;
                code = claim_slot(s, key);
                if (code != STATUS_FULL)
                begin
                    r.status = code;
                    r.position = s[POS_W-1:0];
                    return r;
                end
            end
            return r;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task note_key(key_beat_t beat);
            res_beat_t r;
            r = predict_insert(beat);
            case (r.status)
                STATUS_NEW:   n_new++;
                STATUS_FOUND: n_found++;
                default:      n_full++;
            endcase
            pending_results.push_back(r);
        endtask

        task check_result(res_beat_t got);
            res_beat_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending: status %0d pos %0d",
                                          got.status, got.position));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d (expected pos %0d)",
                                          got.status, want.status, want.position));
            if (got.position !== want.position)
                report_mismatch($sformatf("position %0d, expected %0d (status %0d)",
                                          got.position, want.position, want.status));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    logic              key_valid;
    logic              key_ready;
    key_beat_t         key_data;
    logic              res_valid;
    logic              res_ready;
    res_beat_t         res_data;

    hash_table_scoreboard sb;
    bit          sender_idle = 1'b0;
    bit          recv_stall = 1'b0;
    int          idle_pct = 81;
    int unsigned cycle_count = 0;
    int          keys_sent = 0;
    int          size_writes = 0;
    key_beat_t   recent_keys[$];

    hash_insert_quadratic_probe_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_data  (key_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        res_ready <= !(recv_stall && $urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_data);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Entered and left at a falling edge.
    task send_key(key_beat_t beat);
        while (sender_idle && $urandom_range(99) < idle_pct)
        begin
            key_valid <= 1'b0;
            @(negedge clk);
        end
        key_valid <= 1'b1;
        key_data <= beat;
        do
            @(posedge clk);
        while (!key_ready);
        sb.note_key(beat);
        keys_sent++;
        @(negedge clk);
    endtask

    // Drops valid so the last accepted beat is not taken again.
    task wait_idle();
        key_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task write_table_size(logic [SIZE_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.size_cfg = value;
        size_writes++;
    endtask

    // Characters from txt; bytes past the text come from fill.
    function automatic key_beat_t text_key(string txt, logic [LEN_W-1:0] len_field,
                                           logic [63:0] fill);
        key_beat_t b;
        int        k;
        b.key_chars = fill;
        b.key_length = len_field;
        for (k = 0; k < txt.len(); k++)
            b.key_chars[k * 8 +: 8] = txt[k];
        return b;
    endfunction

    // Mix of repeats (found), letter keys with clustered tails (collisions),
    // raw noise and low characters (negative hashes).
    function automatic key_beat_t random_key();
        key_beat_t   b;
        int          pick;
        int          k;
        int unsigned len;
        logic [63:0] noise;
        logic [63:0] mask;

        pick = $urandom_range(99);
        noise = {$urandom, $urandom};
        if (pick < 30 && recent_keys.size() > 0)
        begin
            b = recent_keys[$urandom_range(recent_keys.size() - 1)];
            len = (b.key_length > 8) ? 8 : b.key_length;
            if (len < 8)
            begin
                mask = (64'd1 << (len * 8)) - 64'd1;
                b.key_chars = (b.key_chars & mask) | (noise & ~mask);
            end
            else
                b.key_length = LEN_W'(8 + $urandom_range(7));
        end
        else if (pick < 70)
        begin
            len = $urandom_range(1, 8);
            b.key_chars = noise;
            b.key_length = LEN_W'(len);
            for (k = 0; k < int'(len); k++)
                b.key_chars[k * 8 +: 8] = (k + 3 >= int'(len)) ? 8'(CHAR_A + $urandom_range(3))
                                                               : 8'(CHAR_A + $urandom_range(25));
        end
        else if (pick < 90)
        begin
            b.key_chars = noise;
            b.key_length = LEN_W'($urandom_range(15));
        end
        else
        begin
            len = $urandom_range(1, 8);
            b.key_chars = noise;
            b.key_length = LEN_W'(len);
            for (k = 0; k < int'(len); k++)
                b.key_chars[k * 8 +: 8] = 8'($urandom_range(8'h40));
        end
        recent_keys.push_back(b);
        if (recent_keys.size() > 48)
            void'(recent_keys.pop_front());
        return b;
    endfunction

    initial
    begin
        logic [SIZE_W-1:0] phase_sizes [12];
        int p;

        phase_sizes = '{11'd1021, 11'd13, 11'd2047, 11'd7, 11'd1024, 11'd2,
                        11'd101, 11'd0, 11'd31, 11'd1025, 11'd5, 11'd3};
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        key_valid = 1'b0;
        key_data = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset table size
        send_key(text_key("A", 4'd1, 64'd0));
        send_key(text_key("", 4'd0, 64'hDEAD_BEEF_0123_4567));   // empty key, home 0 taken
        send_key(text_key("", 4'd0, '1));                         // same empty key
        send_key(text_key("ZZZ", 4'd3, 64'd0));
        send_key(text_key("", 4'd8, '1));                         // all 0xFF characters
        send_key(text_key("", 4'd15, '1));                        // length clipped to 8
        send_key(text_key("", 4'd8, 64'd0));                      // chars below 'A'
        send_key(text_key("0", 4'd2, 64'd0));
        send_key(text_key("XABC", 4'd4, 64'd0));
        send_key(text_key("YABC", 4'd4, 64'd0));                  // same tail: probes
        send_key(text_key("ZABC", 4'd4, 64'd0));
        send_key(text_key("WABC", 4'd4, 64'd0));
        send_key(text_key("VABC", 4'd4, 64'd0));
        send_key(text_key("XABC", 4'd4, 64'hFFFF_FFFF_0000_0000)); // junk past length
        send_key(text_key("PQRSTUVW", 4'd8, 64'd0));

        // one-slot tables (sizes 1 and 0): no probing; then a two-slot table
        write_table_size(11'd1);
        send_key(text_key("A", 4'd1, 64'd0));
        send_key(text_key("Q", 4'd1, 64'd0));
        write_table_size(11'd0);
        send_key(text_key("A", 4'd1, 64'h1234_5678_0000_0000));
        send_key(text_key("B", 4'd1, 64'd0));
        write_table_size(11'd2);
        send_key(text_key("B", 4'd1, 64'd0));
        send_key(text_key("", 4'd0, 64'h5555_AAAA_5555_AAAA));

        for (p = 0; p < 12; p++)
        begin
            write_table_size(phase_sizes[p]);
            sender_idle = (p % 4 == 1) || (p % 4 == 3);
            recv_stall = (p % 4 == 2) || (p % 4 == 3);
            idle_pct = (p % 4 == 3) ? 36 : 81;
            repeat (38) send_key(random_key());
        end
        sender_idle = 1'b0;
        recv_stall = 1'b0;

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Summary: %0d keys over %0d table_size writes (0, 1, 2 up to 2047), %0d cycles",
                 keys_sent, size_writes, cycle_count);
        $display("Summary: %0d new, %0d already present, %0d table full; %0d mismatches",
                 sb.n_new, sb.n_found, sb.n_full, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/hiqp_pkg.sv
rtl/hiqp_ram.sv
rtl/hiqp_mod.sv
rtl/hiqp_probe.sv
rtl/hash_insert_quadratic_probe_top.sv
test/tb_hash_insert_quadratic_probe_top.sv
